[src/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, widths, register indexes and the 3-value sorter shared by the
// 3x3 median filter modules.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_W_W    = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int WIN_SIZE   = 9;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd1024;

  typedef logic [PIX_W-1:0] pix_t;

  // window layout: three rows of three, oldest column first in each row
  typedef pix_t [WIN_SIZE-1:0] win_t;

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } sort3_t;

  // sideband that rides along with a result request
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } meta_t;

  function automatic sort3_t sort3(pix_t a, pix_t b, pix_t c);
    pix_t   lo1;
    pix_t   hi1;
    pix_t   m;
    sort3_t s;
    lo1  = (a < b) ? a : b;
    hi1  = (a < b) ? b : a;
    s.hi = (hi1 > c) ? hi1 : c;
    m    = (hi1 > c) ? c : hi1;
    s.lo = (lo1 < m) ? lo1 : m;
    s.md = (lo1 < m) ? m : lo1;
    return s;
  endfunction

endpackage

[src/median_filter_3x3_core.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_core
// 3x3 median filter over a raster pixel stream, two line stores held in
// one RAM, emitting the median for every interior centre pixel.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_pixel
//  out      output     out_valid/out_stall out_median_value, out_center_row,
//                                          out_center_col, out_last_pixel
//  cfg      input      cfg_we              cfg_index, cfg_wdata
//
// one pixel per clock while in_stall is low; a result moves from stage 1
// through the window stage and the median stages into the output register
// line store RAM: read at accept, written back from stage 1 as it advances,
// with a bypass when the write and the next read hit the same column
// in_stall is high while a result sits in the output register under stall;
// the whole pipeline then holds
// synchronous reset clears counters, window and valids and restores the size
// registers; the line store RAM is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module median_filter_3x3_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mf3_pkg::PIX_W-1:0]       in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mf3_pkg::PIX_W-1:0]       out_median_value,
  output logic [mf3_pkg::ROW_W-1:0]       out_center_row,
  output logic [mf3_pkg::COL_OUT_W-1:0]   out_center_col,
  output logic                            out_last_pixel,
  input  logic                            cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mf3_pkg::*;

  localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RAM_W   = 2 * PIX_W;

  // configuration
  logic [CFG_W_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [WW-1:0]      w_eff;
  logic [ROW_W-1:0]   h_eff;

  // position counters
  logic [AW-1:0]    col_r;
  logic [AW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;

  logic        adv;
  logic        accept;
  logic        access;
  logic        emit;
  logic [31:0] col_m1;
  meta_t       cur_meta;

  // stage 1: RAM read in flight
  logic          s1_valid_r;
  logic          s1_emit_r;
  pix_t          s1_px_r;
  logic [AW-1:0] s1_addr_r;
  meta_t         s1_meta_r;

  // RAM and bypass
  logic             ram_we;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;
  logic [RAM_W-1:0] rd_eff;
  logic             fwd_r;
  logic [RAM_W-1:0] fwd_data_r;
  pix_t             upper_px;
  pix_t             middle_px;

  // window stage
  win_t  win_r;
  logic  s2_valid_r;
  meta_t s2_meta_r;

  logic  med_valid;
  pix_t  med_value;
  meta_t med_meta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (width_r < CFG_W_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff = (height_r < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : height_r;
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    access = (32'(col_r) < 32'(w_eff)) && (row_r < h_eff);
    emit   = access && (row_r >= 16'd2) && (32'(col_r) >= 32'd2);
    col_m1 = 32'(col_r) - 32'd1;
    cur_meta.row  = row_r - 16'd1;
    cur_meta.col  = col_m1[COL_OUT_W-1:0];
    cur_meta.last = (32'(row_r) + 32'd1 == 32'(h_eff)) &&
                    (32'(col_r) + 32'd1 == 32'(w_eff));

    // end of row, end of image, or counters stranded by a smaller size
    if (32'(col_r) + 32'd1 >= 32'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (32'(row_r) + 32'd1 >= 32'(h_eff)) ? '0 : row_r + 16'd1;
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
      if (row_r >= h_eff) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept && access;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r <= emit;
      s1_px_r   <= in_pixel;
      s1_addr_r <= col_r;
      s1_meta_r <= cur_meta;
    end
  end

  // entry layout: upper row in the high byte, middle row in the low byte
  assign rd_eff    = fwd_r ? fwd_data_r : ram_rdata;
  assign upper_px  = rd_eff[RAM_W-1:PIX_W];
  assign middle_px = rd_eff[PIX_W-1:0];
  assign ram_we    = adv && s1_valid_r;
  assign ram_wdata = {middle_px, s1_px_r};

  mf3_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_addr_r),
    .wr_data (ram_wdata),
    .rd_en   (accept && access),
    .rd_addr (col_r),
    .rd_data (ram_rdata)
  );

  // bypass the write-back when the next read hits the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (accept && access) begin
      fwd_r <= ram_we && (s1_addr_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && access) begin
      fwd_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
      if (s1_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]     <= win_r[k*3 + 1];
          win_r[k*3 + 1] <= win_r[k*3 + 2];
        end
        win_r[2] <= upper_px;
        win_r[5] <= middle_px;
        win_r[8] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  mf3_median u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (s2_valid_r),
    .in_win     (win_r),
    .in_meta    (s2_meta_r),
    .out_valid  (med_valid),
    .out_median (med_value),
    .out_meta   (med_meta)
  );

  assign out_valid        = med_valid;
  assign out_median_value = med_value;
  assign out_center_row   = med_meta.row;
  assign out_center_col   = med_meta.col;
  assign out_last_pixel   = med_meta.last;

endmodule

[src/mf3_ram.sv]
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port, registered read
// data that holds while no read is issued. Read during write returns the
// old contents.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/mf3_median.sv]
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine pipeline: sort each window row, take the
// max of the lows, median of the mids and min of the highs, then the
// median of those three. The last stage is the output register.
// ----------------------------------------------------------------------------
module mf3_median (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  mf3_pkg::win_t  in_win,
  input  mf3_pkg::meta_t in_meta,
  output logic           out_valid,
  output mf3_pkg::pix_t  out_median,
  output mf3_pkg::meta_t out_meta
);
  import mf3_pkg::*;

  logic   c_valid_r;
  sort3_t c_row0_r;
  sort3_t c_row1_r;
  sort3_t c_row2_r;
  meta_t  c_meta_r;

  logic   d_valid_r;
  pix_t   d_lo_r;
  pix_t   d_mid_r;
  pix_t   d_hi_r;
  meta_t  d_meta_r;

  logic   e_valid_r;
  pix_t   e_median_r;
  meta_t  e_meta_r;

  sort3_t lows;
  sort3_t mids;
  sort3_t highs;
  sort3_t last3;

  always_comb begin
    lows  = sort3(c_row0_r.lo, c_row1_r.lo, c_row2_r.lo);
    mids  = sort3(c_row0_r.md, c_row1_r.md, c_row2_r.md);
    highs = sort3(c_row0_r.hi, c_row1_r.hi, c_row2_r.hi);
    last3 = sort3(d_lo_r, d_mid_r, d_hi_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= in_valid;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_row0_r   <= sort3(in_win[0], in_win[1], in_win[2]);
      c_row1_r   <= sort3(in_win[3], in_win[4], in_win[5]);
      c_row2_r   <= sort3(in_win[6], in_win[7], in_win[8]);
      c_meta_r   <= in_meta;
      d_lo_r     <= lows.hi;
      d_mid_r    <= mids.md;
      d_hi_r     <= highs.lo;
      d_meta_r   <= c_meta_r;
      e_median_r <= last3.md;
      e_meta_r   <= d_meta_r;
    end
  end

  assign out_valid  = e_valid_r;
  assign out_median = e_median_r;
  assign out_meta   = e_meta_r;

endmodule
